/* hdl/tfn_pkg.sv */
// Shared types and widths for the triangle face normal pipeline.
// No dependencies.
`default_nettype none
package tfn_pkg;
    localparam int SQRT_CELLS = 35;   // root bits of a 70-bit sum of squares
    localparam int DIV_CELLS  = 15;   // quotient bits, max value 16384
    localparam logic [14:0] ONE_Q14 = 15'd16384;

    typedef struct packed {
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
        logic signed [15:0] bx;
        logic signed [15:0] by_coord;
        logic signed [15:0] bz;
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        logic signed [15:0] cz;
    } t_tri;

    typedef struct packed {
        logic signed [15:0] norm_x;
        logic signed [15:0] norm_y;
        logic signed [15:0] norm_z;
        logic               degenerate;
    } t_norm;

    // square root cell payload: cross product, remainder, partial root
    typedef struct packed {
        logic [2:0][34:0] n;
        logic [69:0]      x;
        logic [69:0]      res;
    } t_sq_stage;

    // divider cell payload: signs, deg flag, length, remainders, quotients
    typedef struct packed {
        logic [2:0]       neg;
        logic             deg;
        logic [34:0]      len;
        logic [2:0][49:0] r;
        logic [2:0][14:0] q;
    } t_dv_stage;
endpackage
`default_nettype wire

/* hdl/tfn_if.sv */
// Valid/ready channel interfaces for the triangle face normal block.
// Depends on tfn_pkg.
`default_nettype none
interface tfn_tri_if;
    import tfn_pkg::*;
    logic valid;
    logic ready;
    t_tri data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tfn_norm_if;
    import tfn_pkg::*;
    logic  valid;
    logic  ready;
    t_norm data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tfn_cfg_if;
    logic        valid;
    logic        ready;
    logic [23:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* hdl/tfn_front.sv */
// Front pipeline: edges, cross product, squares and their sum (5 stages).
// Depends on tfn_pkg.
`default_nettype none
module tfn_front (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_en,
    input  wire                     i_v,
    input  wire tfn_pkg::t_tri      i_d,
    output logic                    o_v,
    output tfn_pkg::t_sq_stage      o_d
);
    import tfn_pkg::*;

    logic [4:0]         r_v;
    logic signed [16:0] r_e1 [3];
    logic signed [16:0] r_e2 [3];
    logic signed [33:0] r_p [6];
    logic signed [34:0] r_n3 [3];
    logic signed [34:0] r_n4 [3];
    logic [67:0]        r_sq [3];
    logic [2:0][34:0]   r_n5;
    logic [69:0]        r_s;
    logic [33:0]        w_m [3];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_m[c] = r_n3[c][34] ? 34'(-r_n3[c]) : r_n3[c][33:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[3:0], i_v};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_e1[0] <= 17'(i_d.bx) - 17'(i_d.ax);
            r_e1[1] <= 17'(i_d.by_coord) - 17'(i_d.ay);
            r_e1[2] <= 17'(i_d.bz) - 17'(i_d.az);
            r_e2[0] <= 17'(i_d.cx) - 17'(i_d.ax);
            r_e2[1] <= 17'(i_d.cy) - 17'(i_d.ay);
            r_e2[2] <= 17'(i_d.cz) - 17'(i_d.az);
            r_p[0]  <= r_e1[1] * r_e2[2];
            r_p[1]  <= r_e1[2] * r_e2[1];
            r_p[2]  <= r_e1[2] * r_e2[0];
            r_p[3]  <= r_e1[0] * r_e2[2];
            r_p[4]  <= r_e1[0] * r_e2[1];
            r_p[5]  <= r_e1[1] * r_e2[0];
            for (int c = 0; c < 3; c++) begin
                r_n3[c] <= 35'(r_p[2*c]) - 35'(r_p[2*c+1]);
                r_n4[c] <= r_n3[c];
                r_sq[c] <= 68'(w_m[c]) * 68'(w_m[c]);
                r_n5[c] <= r_n4[c];
            end
            r_s <= 70'(r_sq[0]) + 70'(r_sq[1]) + 70'(r_sq[2]);
        end
    end

    assign o_v     = r_v[4];
    assign o_d.n   = r_n5;
    assign o_d.x   = r_s;
    assign o_d.res = '0;
endmodule
`default_nettype wire

/* hdl/tfn_sqrt_cell.sv */
// One root bit of the integer square root; a row of these forms the root.
// Depends on tfn_pkg.
`default_nettype none
module tfn_sqrt_cell (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_en,
    input  wire  [5:0]              i_idx,
    input  wire                     i_v,
    input  wire tfn_pkg::t_sq_stage i_d,
    output logic                    o_v,
    output tfn_pkg::t_sq_stage      o_d
);
    import tfn_pkg::*;

    logic [69:0] w_one;
    logic [69:0] w_trial;

    // cell k tests root bit 34-k; its square 4^(34-k) is the trial weight
    assign w_one   = 70'(1) << (7'd68 - {i_idx, 1'b0});
    assign w_trial = i_d.res + w_one;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_v <= 1'b0;
        end else if (i_en) begin
            o_v <= i_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_d.n <= i_d.n;
            if (i_d.x >= w_trial) begin
                o_d.x   <= i_d.x - w_trial;
                o_d.res <= (i_d.res >> 1) + w_one;
            end else begin
                o_d.x   <= i_d.x;
                o_d.res <= i_d.res >> 1;
            end
        end
    end
endmodule
`default_nettype wire

/* hdl/tfn_div_cell.sv */
// One quotient bit for all three components of the normal.
// Depends on tfn_pkg.
`default_nettype none
module tfn_div_cell (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_en,
    input  wire  [3:0]              i_idx,
    input  wire                     i_v,
    input  wire tfn_pkg::t_dv_stage i_d,
    output logic                    o_v,
    output tfn_pkg::t_dv_stage      o_d
);
    import tfn_pkg::*;

    logic [49:0] w_div;

    // cell k weighs quotient bit 14-k
    assign w_div = 50'(i_d.len) << (4'd14 - i_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_v <= 1'b0;
        end else if (i_en) begin
            o_v <= i_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_d.neg <= i_d.neg;
            o_d.deg <= i_d.deg;
            o_d.len <= i_d.len;
            for (int c = 0; c < 3; c++) begin
                if (i_d.r[c] >= w_div) begin
                    o_d.r[c] <= i_d.r[c] - w_div;
                    o_d.q[c] <= {i_d.q[c][13:0], 1'b1};
                end else begin
                    o_d.r[c] <= i_d.r[c];
                    o_d.q[c] <= {i_d.q[c][13:0], 1'b0};
                end
            end
        end
    end
endmodule
`default_nettype wire

/* hdl/triangle_face_normal.sv */
// Triangle face normal: cross product, length and unit normal in Q1.14.
// Depends on tfn_pkg, tfn_if, tfn_front, tfn_sqrt_cell, tfn_div_cell.
//
// Channels: i_tri carries one triangle a beat (nine Q8.8 coordinates),
// o_norm one unit normal a beat with the degenerate flag, i_cfg writes
// min_length (Q8.16 length at or below which the normal is zeroed).
// i_cfg is always ready; write it only while the block is empty.
// Throughput: one triangle per cycle while the skid register is empty.
// Path to o_norm.valid: 5 front stages, 35 square root cells, one prep
// stage, 15 divider cells, one final stage and the output reg.
// A skid register behind the output lets the pipe keep moving while the
// receiver stalls until the next result lands in it; then i_tri.ready
// drops and the whole pipe holds until o_norm.ready returns.
// Reset clears all valid bits and sets min_length to zero.
`default_nettype none
module triangle_face_normal (
    input  wire        i_clk,
    input  wire        i_rst_n,
    tfn_tri_if.sink    i_tri,
    tfn_norm_if.source o_norm,
    tfn_cfg_if.sink    i_cfg
);
    import tfn_pkg::*;

    logic        r_skid_v;
    t_norm       r_skid;
    logic        r_out_v;
    t_norm       r_out;
    logic [23:0] r_min_length;
    logic        w_en;

    logic      w_sq_v [SQRT_CELLS+1];
    t_sq_stage w_sq_d [SQRT_CELLS+1];
    logic      w_dv_v [DIV_CELLS+1];
    t_dv_stage w_dv_d [DIV_CELLS+1];

    logic        r_prep_v;
    t_dv_stage   r_prep;
    logic        r_fin_v;
    t_norm       r_fin;
    logic [34:0] w_len;
    logic [33:0] w_m [3];
    logic [14:0] w_qs [3];
    logic [15:0] w_mag [3];
    logic [15:0] w_comp [3];

    assign w_en        = !r_skid_v;
    assign i_tri.ready = w_en;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_length <= '0;
        end else if (i_cfg.valid) begin
            r_min_length <= i_cfg.data;
        end
    end

    tfn_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_v     (i_tri.valid),
        .i_d     (i_tri.data),
        .o_v     (w_sq_v[0]),
        .o_d     (w_sq_d[0])
    );

    for (genvar k = 0; k < SQRT_CELLS; k++) begin : g_sqrt
        tfn_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_idx   (6'(k)),
            .i_v     (w_sq_v[k]),
            .i_d     (w_sq_d[k]),
            .o_v     (w_sq_v[k+1]),
            .o_d     (w_sq_d[k+1])
        );
    end

    // prep: degenerate test and numerators |n| * 2^14 + len / 2
    assign w_len = w_sq_d[SQRT_CELLS].res[34:0];
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_m[c] = w_sq_d[SQRT_CELLS].n[c][34] ?
                     34'(-w_sq_d[SQRT_CELLS].n[c]) : w_sq_d[SQRT_CELLS].n[c][33:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prep_v <= 1'b0;
        end else if (w_en) begin
            r_prep_v <= w_sq_v[SQRT_CELLS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_prep.len <= w_len;
            r_prep.deg <= (w_len <= 35'(r_min_length));
            for (int c = 0; c < 3; c++) begin
                r_prep.neg[c] <= w_sq_d[SQRT_CELLS].n[c][34];
                r_prep.r[c]   <= 50'({w_m[c], 14'b0}) + 50'(w_len >> 1);
                r_prep.q[c]   <= '0;
            end
        end
    end

    assign w_dv_v[0] = r_prep_v;
    assign w_dv_d[0] = r_prep;

    for (genvar k = 0; k < DIV_CELLS; k++) begin : g_div
        tfn_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_idx   (4'(k)),
            .i_v     (w_dv_v[k]),
            .i_d     (w_dv_d[k]),
            .o_v     (w_dv_v[k+1]),
            .o_d     (w_dv_d[k+1])
        );
    end

    // final: saturate, sign, zero when degenerate
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_qs[c]  = (w_dv_d[DIV_CELLS].q[c] > ONE_Q14) ? ONE_Q14
                                                          : w_dv_d[DIV_CELLS].q[c];
            w_mag[c] = {1'b0, w_qs[c]};
            if (w_dv_d[DIV_CELLS].deg) begin
                w_comp[c] = '0;
            end else if (w_dv_d[DIV_CELLS].neg[c]) begin
                w_comp[c] = -w_mag[c];
            end else begin
                w_comp[c] = w_mag[c];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_v <= 1'b0;
        end else if (w_en) begin
            r_fin_v <= w_dv_v[DIV_CELLS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_fin.norm_x     <= w_comp[0];
            r_fin.norm_y     <= w_comp[1];
            r_fin.norm_z     <= w_comp[2];
            r_fin.degenerate <= w_dv_d[DIV_CELLS].deg;
        end
    end

    // output register with skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || o_norm.ready) begin
            r_out_v  <= r_skid_v || r_fin_v;
            r_skid_v <= 1'b0;
        end else if (r_fin_v && w_en) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || o_norm.ready) begin
            r_out <= r_skid_v ? r_skid : r_fin;
        end else if (r_fin_v && w_en) begin
            r_skid <= r_fin;
        end
    end

    assign o_norm.valid = r_out_v;
    assign o_norm.data  = r_out;
endmodule
`default_nettype wire

/* tb/tfn_checker.sv */
// Checker for the triangle face normal block: watches the triangle, normal and
// config channels, predicts each normal and compares it field by field.
// Depends on tfn_pkg and tfn_if.
module tfn_checker (
    input  wire   i_clk,
    input  wire   i_rst_n,
    tfn_tri_if    tri_ch,
    tfn_norm_if   norm_ch,
    tfn_cfg_if    cfg_ch,
    output int    o_errors,
    output int    o_pending,
    output int    o_tri_beats,
    output int    o_norm_beats,
    output int    o_deg_beats
);
    import tfn_pkg::*;

    logic [23:0] min_len;
    t_norm       normals_due[$];

    function automatic logic [15:0] scale_axis(longint n, longint unsigned len);
        longint unsigned m;
        longint unsigned q;
        m = (n < 0) ? longint'(-n) : longint'(n);
        q = (m * 64'd16384 + (len >> 1)) / len;
        if (q > 64'd16384) q = 64'd16384;
        if (n < 0) q = -q;
        return q[15:0];
    endfunction

    function automatic t_norm face_normal(t_tri t, logic [23:0] thr);
        longint e1x, e1y, e1z, e2x, e2y, e2z, nx, ny, nz;
        logic [71:0] sum;
        logic [71:0] trial;
        longint unsigned root;
        t_norm r;
        e1x = longint'(t.bx) - t.ax;
        e1y = longint'(t.by_coord) - t.ay;
        e1z = longint'(t.bz) - t.az;
        e2x = longint'(t.cx) - t.ax;
        e2y = longint'(t.cy) - t.ay;
        e2z = longint'(t.cz) - t.az;
        nx = e1y * e2z - e1z * e2y;
        ny = e1z * e2x - e1x * e2z;
        nz = e1x * e2y - e1y * e2x;
        // squares fit in 68 bits; sum in 70
        sum = 72'($signed(72'(nx)) * $signed(72'(nx)))
            + 72'($signed(72'(ny)) * $signed(72'(ny)))
            + 72'($signed(72'(nz)) * $signed(72'(nz)));
        root = 0;
        for (int b = 35; b >= 0; b--) begin
            trial = 72'(root | (64'd1 << b));
            if (trial * trial <= sum) root = root | (64'd1 << b);
        end
        if (root <= thr || root == 0) begin
            r = '0;
            r.degenerate = 1'b1;
        end else begin
            r.norm_x = scale_axis(nx, root);
            r.norm_y = scale_axis(ny, root);
            r.norm_z = scale_axis(nz, root);
            r.degenerate = 1'b0;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_norm want;
        if (!i_rst_n) begin
            min_len      <= '0;
            o_errors     <= 0;
            o_pending    <= 0;
            o_tri_beats  <= 0;
            o_norm_beats <= 0;
            o_deg_beats  <= 0;
        end else begin
            if (cfg_ch.valid && cfg_ch.ready) min_len <= cfg_ch.data;
            if (tri_ch.valid && tri_ch.ready) begin
                normals_due = {normals_due, face_normal(tri_ch.data, min_len)};
                o_tri_beats <= o_tri_beats + 1;
            end
            if (norm_ch.valid && norm_ch.ready) begin
                o_norm_beats <= o_norm_beats + 1;
                if (norm_ch.data.degenerate) o_deg_beats <= o_deg_beats + 1;
                if (normals_due.size() == 0) begin
                    $error("normal beat with nothing expected");
                    o_errors <= o_errors + 1;
                end else begin
                    want = normals_due.pop_front();
                    if (want != norm_ch.data) o_errors <= o_errors + 1;
                    if (want.norm_x != norm_ch.data.norm_x)
                        $error("norm_x: expected %0d, got %0d", want.norm_x,
                               norm_ch.data.norm_x);
                    if (want.norm_y != norm_ch.data.norm_y)
                        $error("norm_y: expected %0d, got %0d", want.norm_y,
                               norm_ch.data.norm_y);
                    if (want.norm_z != norm_ch.data.norm_z)
                        $error("norm_z: expected %0d, got %0d", want.norm_z,
                               norm_ch.data.norm_z);
                    if (want.degenerate != norm_ch.data.degenerate)
                        $error("degenerate: expected %0b, got %0b", want.degenerate,
                               norm_ch.data.degenerate);
                end
            end
            o_pending <= normals_due.size();
        end
    end
endmodule

/* tb/tb_top.sv */
// Testbench top for triangle_face_normal: drives triangles and min_length
// writes with random idling and a long output stall, then gives the verdict.
// Depends on tfn_pkg, tfn_if, tfn_checker and the block's RTL.
module tb_top;
    import tfn_pkg::*;

    localparam int LATENCY    = 58;
    localparam int HANG_LIMIT = 4000;

    logic i_clk;
    logic i_rst_n;
    int   errors, pending, tri_beats, norm_beats, deg_beats;
    int   src_idle_pct, snk_idle_pct;
    int   stall_len;
    int   quiet_cycles;

    tfn_tri_if  tri_ch ();
    tfn_norm_if norm_ch ();
    tfn_cfg_if  cfg_ch ();

    triangle_face_normal dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tri   (tri_ch),
        .o_norm  (norm_ch),
        .i_cfg   (cfg_ch)
    );

    tfn_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .tri_ch       (tri_ch),
        .norm_ch      (norm_ch),
        .cfg_ch       (cfg_ch),
        .o_errors     (errors),
        .o_pending    (pending),
        .o_tri_beats  (tri_beats),
        .o_norm_beats (norm_beats),
        .o_deg_beats  (deg_beats)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        tri_ch.valid  = 1'b0;
        tri_ch.data   = '0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.data   = '0;
        norm_ch.ready = 1'b0;
        i_rst_n       = 1'b0;
        src_idle_pct  = 0;
        snk_idle_pct  = 0;
        stall_len     = 0;
    end

    // receiver: random stalls, plus a long hold-off when requested
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            norm_ch.ready <= 1'b0;
        end else if (stall_len > 0) begin
            norm_ch.ready <= 1'b0;
            stall_len     <= stall_len - 1;
        end else begin
            norm_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // watchdog on cycles with no beat anywhere
    always @(posedge i_clk) begin
        if (!i_rst_n || (tri_ch.valid && tri_ch.ready) || (norm_ch.valid && norm_ch.ready)
            || stall_len > 0)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > HANG_LIMIT) begin
            $display("timeout: no beat for %0d cycles", quiet_cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // valid stays up after the beat so that back-to-back beats need no gap
    task automatic send_tri(t_tri t);
        while ($urandom_range(99) < src_idle_pct) begin
            tri_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        tri_ch.valid <= 1'b1;
        tri_ch.data  <= t;
        do @(posedge i_clk); while (!tri_ch.ready);
    endtask

    task automatic write_min_length(logic [23:0] v);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= v;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        tri_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_coord(int span);
        case ($urandom_range(5))
            0:       return 16'($urandom);
            1:       return $urandom_range(1) ? 16'h7fff : 16'h8000;
            default: return 16'($signed($urandom_range(2 * span)) - span);
        endcase
    endfunction

    function automatic t_tri rand_tri();
        t_tri t;
        int   span;
        span = $urandom_range(3) == 0 ? 32767 : $urandom_range(3) * 600 + 8;
        t.ax = rand_coord(span); t.ay = rand_coord(span); t.az = rand_coord(span);
        t.bx = rand_coord(span); t.by_coord = rand_coord(span); t.bz = rand_coord(span);
        t.cx = rand_coord(span); t.cy = rand_coord(span); t.cz = rand_coord(span);
        case ($urandom_range(9))
            0: begin t.bx = t.ax; t.by_coord = t.ay; t.bz = t.az; end  // repeated vertex
            1: begin                                                  // nearly collinear
                t.cx = t.bx; t.cy = t.by_coord; t.cz = t.bz;
                t.bx = t.ax + ((t.cx - t.ax) >>> 1);
                t.by_coord = t.ay + ((t.cy - t.ay) >>> 1);
                t.bz = t.az + ((t.cz - t.az) >>> 1);
            end
            2: begin                                                  // b.xy, c.z near a
                t.bx = t.ax + $signed(4'($urandom)); t.by_coord = t.ay + $signed(4'($urandom));
                t.cz = t.az + $signed(4'($urandom)); t.cx = t.ax;
            end
            default: ;
        endcase
        return t;
    endfunction

    function automatic t_tri make_tri(logic [15:0] a0, a1, a2, b0, b1, b2, c0, c1, c2);
        t_tri t;
        t = '{a0, a1, a2, b0, b1, b2, c0, c1, c2};
        return t;
    endfunction

    localparam logic [23:0] THR [5] = '{24'd0, 24'd300, 24'd65536, 24'd4000000, 24'hffffff};

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: axis-aligned normals, extremes, zero and tiny lengths
        send_tri(make_tri(0, 0, 0, 16'h0100, 0, 0, 0, 16'h0100, 0));
        send_tri(make_tri(0, 0, 0, 0, 16'h0100, 0, 16'h0100, 0, 0));
        send_tri(make_tri(0, 0, 0, 0, 0, 16'h0100, 16'h0100, 0, 0));
        send_tri(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_tri(make_tri(16'h1234, 16'h8000, 16'h7fff, 16'h1234, 16'h8000, 16'h7fff,
                          1, 2, 3));
        send_tri(make_tri(16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h8000,
                          16'h8000, 16'h7fff, 16'h8000));
        send_tri(make_tri(16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
                          16'h8000, 16'h8000, 16'h7fff));
        send_tri(make_tri(16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff,
                          16'h7fff, 16'h7fff, 16'h8000));
        send_tri(make_tri(0, 0, 0, 1, 0, 0, 0, 1, 0));
        send_tri(make_tri(0, 0, 0, 1, 1, 0, 0, 1, 1));
        send_tri(make_tri(0, 0, 0, 16'hffff, 0, 0, 0, 16'hffff, 0));
        send_tri(make_tri(5, 7, 0, 16'hfffd, 9, 1, 2, 16'hfff0, 16'hffff));
        send_tri(make_tri(0, 0, 0, 16'h0300, 16'h0100, 0, 16'h0100, 16'h0200, 16'h0500));
        send_tri(make_tri(0, 0, 0, 16'h0200, 16'h0400, 16'h0600, 16'h0100, 16'h0200, 16'h0300));
        drain();
        write_min_length(24'd65536);   // unit-ish edges now sit at the threshold
        send_tri(make_tri(0, 0, 0, 16'h0100, 0, 0, 0, 16'h0100, 0));
        send_tri(make_tri(0, 0, 0, 16'h0100, 0, 0, 0, 16'h0101, 0));
        send_tri(make_tri(0, 0, 0, 16'h0100, 0, 0, 0, 16'h00ff, 0));
        drain();
        write_min_length(24'hffffff);
        send_tri(make_tri(16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h8000,
                          16'h8000, 16'h7fff, 16'h8000));
        send_tri(make_tri(0, 0, 0, 16'h1000, 0, 0, 0, 16'h1000, 0));
        drain();

        // random phases: receiver-heavy idling, sender-heavy, then none
        for (int ph = 0; ph < 3; ph++) begin
            src_idle_pct = (ph == 0) ? 19 : (ph == 1) ? 60 : 0;
            snk_idle_pct = (ph == 0) ? 60 : (ph == 1) ? 19 : 0;
            for (int s = 0; s < 5; s++) begin
                write_min_length((ph == 2 && s == 4) ? 24'($urandom) : THR[(s + ph) % 5]);
                for (int k = 0; k < 70; k++) begin
                    if (ph == 2 && s == 1 && k == 10) stall_len = 300;
                    send_tri(rand_tri());
                end
                drain();
            end
        end

        $display("covered %0d triangles, %0d normals, %0d degenerate, over several thresholds",
                 tri_beats, norm_beats, deg_beats);
        if (errors == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

/* triangle_face_normal.f */
hdl/tfn_pkg.sv
hdl/tfn_if.sv
hdl/tfn_front.sv
hdl/tfn_sqrt_cell.sv
hdl/tfn_div_cell.sv
hdl/triangle_face_normal.sv
tb/tfn_checker.sv
tb/tb_top.sv
